@@ sv/iscp_pkg.sv @@
// ----------------------------------------------------------------------------
// iscp_pkg
// Shared types, constants and palette lookup for the inline style code parser.
// ----------------------------------------------------------------------------
package iscp_pkg;

	localparam int PALETTE_SIZE_DEF = 26;
	localparam int COLOR_IDX_W      = 5;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESET_CODE     = 3'd0,
		REG_BOLD_CODE      = 3'd1,
		REG_ITALIC_CODE    = 3'd2,
		REG_UNDERLINE_CODE = 3'd3,
		REG_CONTROL_LIMIT  = 3'd4,
		REG_COLOR_FIRST    = 3'd5,
		REG_COLOR_LAST     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] reset_code;
		logic [7:0] bold_code;
		logic [7:0] italic_code;
		logic [7:0] underline_code;
		logic [7:0] control_limit;
		logic [7:0] color_first;
		logic [7:0] color_last;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		reset_code:     8'd255,
		bold_code:      8'd2,
		italic_code:    8'd22,
		underline_code: 8'd31,
		control_limit:  8'd31,
		color_first:    8'd1,
		color_last:     8'd26
	};

	typedef struct packed {
		logic [COLOR_IDX_W-1:0] color_index;
		logic [COLOR_IDX_W-1:0] saved_color_index;
		logic [7:0]             last_color_byte;
		logic                   bold_flag;
		logic                   italic_flag;
		logic                   underline_flag;
		logic                   pending_run_start;
	} style_state_t;

	localparam style_state_t STYLE_RESET = '{
		color_index:       '0,
		saved_color_index: '0,
		last_color_byte:   8'd0,
		bold_flag:         1'b0,
		italic_flag:       1'b0,
		underline_flag:    1'b0,
		pending_run_start: 1'b1
	};

	typedef struct packed {
		logic [7:0] text_byte;
	} text_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       bold_on;
		logic       italic_on;
		logic       underline_on;
		logic       run_first;
		logic       string_end;
	} style_item_t;

	function automatic logic [23:0] palette_rgb(input logic [COLOR_IDX_W-1:0] idx);
		logic [23:0] rgb;
		case (idx)
			5'd2:    rgb = 24'h00FFFF;
			5'd4:    rgb = 24'h0000FF;
			5'd5:    rgb = 24'h7F7F7F;
			5'd7:    rgb = 24'hFF00FF;
			5'd10:   rgb = 24'h7F7F7F;
			5'd11:   rgb = 24'h007F00;
			5'd13:   rgb = 24'h00FF00;
			5'd14:   rgb = 24'hBFBFBF;
			5'd15:   rgb = 24'h7F0000;
			5'd16:   rgb = 24'h00007F;
			5'd17:   rgb = 24'h7F7F00;
			5'd18:   rgb = 24'h7F007F;
			5'd19:   rgb = 24'hFF0000;
			5'd20:   rgb = 24'hBFBFBF;
			5'd22:   rgb = 24'h007F7F;
			5'd23:   rgb = 24'hFFFFFF;
			5'd24:   rgb = 24'hFFFF00;
			default: rgb = 24'h000000;
		endcase
		return rgb;
	endfunction

endpackage

@@ sv/iscp_stream_if.sv @@
// ----------------------------------------------------------------------------
// iscp_stream_if
// Valid/ready stream channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface iscp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/inline_style_code_parser_top.sv @@
// ----------------------------------------------------------------------------
// inline_style_code_parser_top
// Inline style code parser: turns a byte stream with embedded style controls
// into styled text words.
//
// text carries one string byte per word; a zero byte ends the string. style
// carries one result word per text byte (with palette RGB, bold, italic,
// underline and run start) and one end marker word per terminator. Control
// bytes update the style state and produce no word.
// The configuration port writes register cfg_index with cfg_data on any edge
// with cfg_we high; write only while the parser is idle.
// Throughput is one byte per cycle while style is not stalled. A byte accepted
// into the input register is decoded combinationally and written into the
// output register, where its result word appears and can be taken. The style
// state update is a loop through the style state register and its decode.
// Reset restores the default codes, clears the style state and empties both
// the input and output registers. When style is stalled the output register
// holds its word, the input register holds the next byte and text.ready
// drops until the stall clears.
// ----------------------------------------------------------------------------
module inline_style_code_parser_top import iscp_pkg::*; #(
	parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	iscp_stream_if.sink           text,
	iscp_stream_if.source         style
);

	cfg_t        cfg;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        can_push;
	logic        advance;
	logic        res_valid;
	style_item_t res;

	iscp_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance    = valid_s1 && can_push;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.data.text_byte;
		end
	end

	iscp_style_core #(
		.PALETTE_SIZE (PALETTE_SIZE)
	) u_style_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	iscp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && res_valid),
		.push_data (res),
		.can_push  (can_push),
		.style     (style)
	);

endmodule

@@ sv/iscp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// iscp_cfg_regs
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module iscp_cfg_regs import iscp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RESET_CODE:     cfg_q.reset_code     <= cfg_data;
				REG_BOLD_CODE:      cfg_q.bold_code      <= cfg_data;
				REG_ITALIC_CODE:    cfg_q.italic_code    <= cfg_data;
				REG_UNDERLINE_CODE: cfg_q.underline_code <= cfg_data;
				REG_CONTROL_LIMIT:  cfg_q.control_limit  <= cfg_data;
				REG_COLOR_FIRST:    cfg_q.color_first    <= cfg_data;
				REG_COLOR_LAST:     cfg_q.color_last     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/iscp_style_core.sv @@
// ----------------------------------------------------------------------------
// iscp_style_core
// Style state registers and the per-word decode of text, control and
// terminator bytes.
// ----------------------------------------------------------------------------
module iscp_style_core import iscp_pkg::*; #(
	parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        advance,
	input  logic [7:0]  byte_s1,
	output logic        res_valid,
	output style_item_t res
);

	style_state_t st_q;
	style_state_t st_nxt;

	logic       is_term;
	logic       ctrl_hit;
	logic       in_range;
	logic [7:0] color_off;
	logic       color_ok;
	logic [23:0] rgb;

	assign is_term    = (byte_s1 == 8'd0);
	assign ctrl_hit   = (byte_s1 == cfg.reset_code) || (byte_s1 <= cfg.control_limit);
	assign in_range   = (byte_s1 >= cfg.color_first) && (byte_s1 <= cfg.color_last);
	assign color_off  = byte_s1 - cfg.color_first;
	assign color_ok   = in_range && (color_off < 8'(PALETTE_SIZE));
	assign rgb        = palette_rgb(st_q.color_index);

	always_comb begin
		st_nxt    = st_q;
		res_valid = 1'b0;
		res       = '0;
		if (is_term) begin
			res_valid      = 1'b1;
			res.string_end = 1'b1;
			st_nxt         = STYLE_RESET;
		end else if (!ctrl_hit) begin
			res_valid        = 1'b1;
			res.out_byte     = byte_s1;
			res.red          = rgb[23:16];
			res.green        = rgb[15:8];
			res.blue         = rgb[7:0];
			res.bold_on      = st_q.bold_flag;
			res.italic_on    = st_q.italic_flag;
			res.underline_on = st_q.underline_flag;
			res.run_first    = st_q.pending_run_start;
			st_nxt.pending_run_start = 1'b0;
		end else begin
			st_nxt.pending_run_start = 1'b1;
			if (byte_s1 == cfg.reset_code) begin
				st_nxt = STYLE_RESET;
			end else if (byte_s1 == cfg.bold_code) begin
				st_nxt.bold_flag = ~st_q.bold_flag;
			end else if (byte_s1 == cfg.italic_code) begin
				st_nxt.italic_flag = ~st_q.italic_flag;
			end else if (byte_s1 == cfg.underline_code) begin
				st_nxt.underline_flag = ~st_q.underline_flag;
			end else if (color_ok) begin
				if (byte_s1 == st_q.last_color_byte) begin
					st_nxt.color_index     = st_q.saved_color_index;
					st_nxt.last_color_byte = 8'd0;
				end else begin
					st_nxt.saved_color_index = st_q.color_index;
					st_nxt.last_color_byte   = byte_s1;
					st_nxt.color_index       = color_off[COLOR_IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STYLE_RESET;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_term |=> st_q == STYLE_RESET)
		else $error("state not cleared after terminator");

	a_end_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.string_end |-> res.out_byte == 8'd0 && res.red == 8'd0
			&& res.green == 8'd0 && res.blue == 8'd0 && !res.run_first)
		else $error("end marker carries style");

	a_text_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_term && !ctrl_hit |=> !st_q.pending_run_start)
		else $error("run start not cleared by text byte");

	a_control_sets_run: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_term && ctrl_hit |=> st_q.pending_run_start && !res_valid
			|| st_q.pending_run_start)
		else $error("run start not set by control byte");

endmodule

@@ sv/iscp_out_reg.sv @@
// ----------------------------------------------------------------------------
// iscp_out_reg
// Output register holding one result word toward the downstream sink.
// ----------------------------------------------------------------------------
module iscp_out_reg import iscp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  style_item_t          push_data,
	output logic                 can_push,
	iscp_stream_if.source        style
);

	logic        valid_q;
	style_item_t data_q;

	assign can_push = !valid_q || style.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push) begin
			data_q <= push_data;
		end
	end

	assign style.valid = valid_q;
	assign style.data  = data_q;

endmodule

@@ tb/inline_style_code_parser_top_test.sv @@
// ----------------------------------------------------------------------------
// inline_style_code_parser_top_test
// Self-checking bench for the inline style code parser. A short scripted
// string under the default codes comes first, then phases of random strings,
// each under its own code setup (defaults, extremes, colliding codes, an
// empty colour range, palette overrun, random). Every accepted byte goes
// through a local style decoder; every style word is compared in order with
// what it predicts, or with the scripted word for literal script rows.
// ----------------------------------------------------------------------------
module inline_style_code_parser_top_test import iscp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 10;
	localparam int PALETTE_ENTRIES = PALETTE_SIZE_DEF;
	localparam int NUM_PHASES      = 14;
	localparam int PHASE_BYTES     = 112;
	localparam int SETTLE_CYCLES   = 4;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_REPORTS     = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic [23:0] RGB_TABLE [32] = '{
		24'h000000, 24'h000000, 24'h00FFFF, 24'h000000,
		24'h0000FF, 24'h7F7F7F, 24'h000000, 24'hFF00FF,
		24'h000000, 24'h000000, 24'h7F7F7F, 24'h007F00,
		24'h000000, 24'h00FF00, 24'hBFBFBF, 24'h7F0000,
		24'h00007F, 24'h7F7F00, 24'h7F007F, 24'hFF0000,
		24'hBFBFBF, 24'h000000, 24'h007F7F, 24'hFFFFFF,
		24'hFFFF00, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000
	};

	localparam style_item_t END_WORD = '{
		out_byte: 8'h00, red: 8'h00, green: 8'h00, blue: 8'h00,
		bold_on: 1'b0, italic_on: 1'b0, underline_on: 1'b0,
		run_first: 1'b0, string_end: 1'b1
	};

	typedef struct packed {
		logic [7:0]  text_byte;
		logic        literal;
		style_item_t word;
	} script_row_t;

	localparam int SCRIPT_LEN = 23;

	// default codes: bold 2, italic 22, underline 31, reset 255, colours 1..26
	script_row_t script [SCRIPT_LEN] = '{
		'{8'h41, 1'b1, '{8'h41, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{8'h42, 1'b1, '{8'h42, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{8'h02, 1'b0, '0},
		'{8'h16, 1'b0, '0},
		'{8'h1F, 1'b0, '0},
		'{8'h03, 1'b0, '0},
		'{8'h20, 1'b0, '0},
		'{8'h03, 1'b0, '0},
		'{8'hFE, 1'b0, '0},
		'{8'h1A, 1'b0, '0},
		'{8'h1B, 1'b0, '0},
		'{8'h14, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h7F, 1'b1, '{8'h7F, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{8'h01, 1'b0, '0},
		'{8'h18, 1'b0, '0},
		'{8'h55, 1'b0, '0},
		'{8'h00, 1'b1, END_WORD},
		'{8'h00, 1'b1, END_WORD},
		'{8'h05, 1'b0, '0},
		'{8'hAA, 1'b0, '0},
		'{8'h00, 1'b1, END_WORD}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	iscp_stream_if #(.payload_t(text_item_t))  text_ch ();
	iscp_stream_if #(.payload_t(style_item_t)) style_ch ();

	inline_style_code_parser_top #(
		.PALETTE_SIZE(PALETTE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.text(text_ch.sink),
		.style(style_ch.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// decoder state
	cfg_t       codes;
	logic [4:0] cur_color;
	logic [4:0] prev_color;
	logic [7:0] last_code;
	logic       bold;
	logic       italic;
	logic       uline;
	logic       fresh_run;

	style_item_t style_queue [$];

	bit text_taken;
	bit gaps_on;
	bit stalls_on;
	int stall_left;
	int cycles;
	int bytes_sent;
	int words_checked;
	int end_markers;
	int mismatches;

	function automatic void clear_style();
		cur_color  = '0;
		prev_color = '0;
		last_code  = 8'h00;
		bold       = 1'b0;
		italic     = 1'b0;
		uline      = 1'b0;
		fresh_run  = 1'b1;
	endfunction

	function automatic bit style_of_byte(input logic [7:0] b, output style_item_t w);
		int idx;
		w = '0;
		if (b == 8'h00) begin
			w.string_end = 1'b1;
			clear_style();
			return 1'b1;
		end
		if (b != codes.reset_code && b > codes.control_limit) begin
			w.out_byte = b;
			{w.red, w.green, w.blue} = RGB_TABLE[cur_color];
			w.bold_on      = bold;
			w.italic_on    = italic;
			w.underline_on = uline;
			w.run_first    = fresh_run;
			fresh_run      = 1'b0;
			return 1'b1;
		end
		fresh_run = 1'b1;
		if (b == codes.reset_code) begin
			clear_style();
		end else if (b == codes.bold_code) begin
			bold = ~bold;
		end else if (b == codes.italic_code) begin
			italic = ~italic;
		end else if (b == codes.underline_code) begin
			uline = ~uline;
		end else if (b >= codes.color_first && b <= codes.color_last) begin
			idx = int'(b) - int'(codes.color_first);
			if (idx < PALETTE_ENTRIES) begin
				if (b == last_code) begin
					cur_color = prev_color;
					last_code = 8'h00;
				end else begin
					prev_color = cur_color;
					last_code  = b;
					cur_color  = idx[4:0];
				end
			end
		end
		return 1'b0;
	endfunction

	// mostly well-formed strings with random content, some raw noise
	function automatic logic [7:0] next_byte();
		int pick;
		int hi;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			if (codes.control_limit == 8'hFF)
				return 8'($urandom_range(1, 255));
			return 8'($urandom_range(int'(codes.control_limit) + 1, 255));
		end
		if (pick < 46)
			return codes.bold_code;
		if (pick < 52)
			return codes.italic_code;
		if (pick < 56)
			return codes.underline_code;
		if (pick < 60)
			return codes.reset_code;
		if (pick < 74 && codes.color_first <= codes.color_last) begin
			hi = codes.color_last;
			if (hi > int'(codes.color_first) + 27)
				hi = int'(codes.color_first) + 27;
			return 8'($urandom_range(codes.color_first, hi));
		end
		if (pick < 80 && last_code != 8'h00)
			return last_code;
		if (pick < 88)
			return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic string word_text(input style_item_t w);
		return $sformatf("byte=%h rgb=%h%h%h b/i/u=%b%b%b run=%b end=%b",
			w.out_byte, w.red, w.green, w.blue, w.bold_on, w.italic_on,
			w.underline_on, w.run_first, w.string_end);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit literal, input style_item_t word);
		style_item_t w;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data  <= '{text_byte: b};
		@(negedge clk);
		while (!text_taken)
			@(negedge clk);
		bytes_sent++;
		if (style_of_byte(b, w))
			style_queue.push_back(literal ? word : w);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_RESET_CODE:     codes.reset_code     = val;
			REG_BOLD_CODE:      codes.bold_code      = val;
			REG_ITALIC_CODE:    codes.italic_code    = val;
			REG_UNDERLINE_CODE: codes.underline_code = val;
			REG_CONTROL_LIMIT:  codes.control_limit  = val;
			REG_COLOR_FIRST:    codes.color_first    = val;
			REG_COLOR_LAST:     codes.color_last     = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain();
		text_ch.valid <= 1'b0;
		while (style_queue.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk)
		text_taken = text_ch.valid && text_ch.ready;

	always @(negedge clk) begin
		if (stall_left > 0) begin
			style_ch.ready <= 1'b0;
			stall_left--;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			style_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			style_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		style_item_t exp_word;
		if (arst_n && style_ch.valid && style_ch.ready) begin
			if (style_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected style word: %s", word_text(style_ch.data));
			end else begin
				exp_word = style_queue.pop_front();
				words_checked++;
				if (exp_word.string_end)
					end_markers++;
				if (style_ch.data !== exp_word) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("style word mismatch\n  expected %s\n  actual   %s",
							word_text(exp_word), word_text(style_ch.data));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				style_queue.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		cfg_t nc;
		int   hi;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		text_ch.valid  = 1'b0;
		text_ch.data   = '0;
		style_ch.ready = 1'b0;
		stall_left     = 0;
		cycles         = 0;
		bytes_sent     = 0;
		words_checked  = 0;
		end_markers    = 0;
		mismatches     = 0;
		codes          = CFG_RESET;
		clear_style();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i])
			send_byte(script[i].text_byte, script[i].literal, script[i].word);
		drain();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: nc = CFG_RESET;
				// every nonzero byte is a control, zero resets and terminates
				1: nc = '{reset_code: 8'd0, bold_code: 8'd1, italic_code: 8'd255,
					underline_code: 8'd128, control_limit: 8'd255,
					color_first: 8'd255, color_last: 8'd255};
				2: nc = '{reset_code: 8'd255, bold_code: 8'd255, italic_code: 8'd1,
					underline_code: 8'd1, control_limit: 8'd1,
					color_first: 8'd1, color_last: 8'd1};
				// colour range runs past the palette
				3: nc = '{reset_code: 8'd200, bold_code: 8'd50, italic_code: 8'd51,
					underline_code: 8'd52, control_limit: 8'd60,
					color_first: 8'd1, color_last: 8'd255};
				// empty colour range, controls below it ignored
				4: nc = '{reset_code: 8'd128, bold_code: 8'd3, italic_code: 8'd4,
					underline_code: 8'd5, control_limit: 8'd40,
					color_first: 8'd30, color_last: 8'd20};
				// colliding codes exercise the priority order
				5: nc = '{reset_code: 8'd3, bold_code: 8'd3, italic_code: 8'd4,
					underline_code: 8'd4, control_limit: 8'd10,
					color_first: 8'd2, color_last: 8'd8};
				6: nc = '{reset_code: 8'd0, bold_code: 8'd20, italic_code: 8'd21,
					underline_code: 8'd22, control_limit: 8'd30,
					color_first: 8'd5, color_last: 8'd30};
				default: begin
					nc.control_limit  = 8'($urandom_range(1, 60));
					nc.color_first    = 8'($urandom_range(1, nc.control_limit));
					hi                = int'(nc.color_first) + 35;
					nc.color_last     = 8'($urandom_range(nc.color_first, hi));
					nc.bold_code      = 8'($urandom_range(1, int'(nc.control_limit) + 4));
					nc.italic_code    = 8'($urandom_range(1, int'(nc.control_limit) + 4));
					nc.underline_code = 8'($urandom_range(1, int'(nc.control_limit) + 4));
					nc.reset_code     = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(REG_RESET_CODE, nc.reset_code);
			write_reg(REG_BOLD_CODE, nc.bold_code);
			write_reg(REG_ITALIC_CODE, nc.italic_code);
			write_reg(REG_UNDERLINE_CODE, nc.underline_code);
			write_reg(REG_CONTROL_LIMIT, nc.control_limit);
			write_reg(REG_COLOR_FIRST, nc.color_first);
			write_reg(REG_COLOR_LAST, nc.color_last);
			if (phase == 0)
				write_reg(REG_UNUSED, 8'h05);
			cfg_we <= 1'b0;

			// no idling at all in the closing phases
			gaps_on   = (phase < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
			stalls_on = (phase < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_BYTES; n++)
				send_byte(next_byte(), 1'b0, '0);
			drain();
		end

		$display("sent %0d bytes over %0d code setups plus a scripted string",
			bytes_sent, NUM_PHASES);
		$display("checked %0d style words (%0d end markers), %0d mismatches",
			words_checked, end_markers, mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ inline_style_code_parser_top.f @@
sv/iscp_pkg.sv
sv/iscp_stream_if.sv
sv/iscp_cfg_regs.sv
sv/iscp_style_core.sv
sv/iscp_out_reg.sv
sv/inline_style_code_parser_top.sv
tb/inline_style_code_parser_top_test.sv
